[rtl/bbe_pkg.sv]
// shared types, widths and codes of the b-spline basis evaluator
package bbe_pkg;

	// fixed field widths
	localparam int KNOT_W     = 32;
	localparam int DIST_W     = 33;
	localparam int DEN_W      = 34;
	localparam int SLOT_W     = 6;
	localparam int IDX_OUT_W  = 6;
	localparam int VAL_OUT_W  = 17;
	localparam int DEG_CFG_W  = 3;
	localparam int CNT_CFG_W  = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// default sizing
	localparam int DEF_MAX_KNOTS  = 64;
	localparam int DEF_MAX_DEGREE = 7;
	localparam int DEF_FRAC_BITS  = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOTS  = 1'd1;

	// register reset values
	localparam logic [DEG_CFG_W-1:0] DEGREE_RST = 3'd3;
	localparam logic [CNT_CFG_W-1:0] KNOTS_RST  = 7'd16;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	// input beat
	typedef struct packed {
		logic                     mode;
		logic [SLOT_W-1:0]        knot_slot;
		logic signed [KNOT_W-1:0] sample_value;
	} bbe_in_t;

	// result beat
	typedef struct packed {
		logic [IDX_OUT_W-1:0] basis_index;
		logic [VAL_OUT_W-1:0] basis_value;
		logic                 last_of_point;
		logic                 zero_divisor;
	} bbe_out_t;

endpackage

[rtl/bspline_basis_evaluator_core.sv]
// top level: knot table, span search and cox-de boor triangle sequencer
//
// Usage: an input beat is taken when start is high and busy is low.
// A load beat (mode 0) writes sample_value into knot slot knot_slot and
// returns nothing; busy stays low, so loads may follow every cycle.
// An evaluate beat (mode 1) takes point x and, unless the knot count is
// below degree+2, yields degree+1 result beats on consecutive cycles,
// each marked by strobe for one cycle; the last carries last_of_point.
// The receiver cannot hold results off.
// From the accepting edge to the first result the block runs a span
// search, knot reads for each triangle row, and per triangle step two
// divisions on the one bit-serial divider (none when the knot distance
// is zero); the d+1 result beats follow. Busy is high until the edge
// that ends the last result beat.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; the user is to write it only while busy is low, which
// the block does not enforce. Reset clears the sequencer and sets degree
// 3 and 16 knots; the knot table holds nothing defined until loaded.
module bspline_basis_evaluator_core #(
	parameter int MAX_KNOTS  = bbe_pkg::DEF_MAX_KNOTS,
	parameter int MAX_DEGREE = bbe_pkg::DEF_MAX_DEGREE,
	parameter int FRAC_BITS  = bbe_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  bbe_pkg::bbe_in_t                 item,
	output logic                             strobe,
	output bbe_pkg::bbe_out_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bbe_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bbe_pkg::*;

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int IW = $clog2(MAX_KNOTS + 2 * MAX_DEGREE + 2) + 1;
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int BW = FRAC_BITS + 1;
	localparam int QW = FRAC_BITS + KNOT_W + 3;

	localparam logic [BW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD1   = 4'd1;
	localparam logic [3:0] S_CHK1  = 4'd2;
	localparam logic [3:0] S_CHKL  = 4'd3;
	localparam logic [3:0] S_BIS   = 4'd4;
	localparam logic [3:0] S_BISW  = 4'd5;
	localparam logic [3:0] S_CLAMP = 4'd6;
	localparam logic [3:0] S_LR    = 4'd7;
	localparam logic [3:0] S_LRL   = 4'd8;
	localparam logic [3:0] S_LRR   = 4'd9;
	localparam logic [3:0] S_DEN   = 4'd10;
	localparam logic [3:0] S_DIVR  = 4'd11;
	localparam logic [3:0] S_DIVL  = 4'd12;
	localparam logic [3:0] S_UPD   = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	// clamp to [0, 1.0]
	function automatic logic [BW-1:0] sat_unit(input logic signed [QW:0] v);
		logic [BW-1:0] res;
		if (v[QW]) begin
			res = '0;
		end else if (v[QW-1:0] > QW'(ONE_Q)) begin
			res = ONE_Q;
		end else begin
			res = v[BW-1:0];
		end
		return res;
	endfunction

	logic [DEG_CFG_W-1:0]     deg_q;
	logic [CNT_CFG_W-1:0]     kcnt_q;
	logic [3:0]               state_q;
	logic signed [KNOT_W-1:0] x_q;
	logic [IW-1:0]            low_q, high_q, mid_q, idx_q;
	logic [DW-1:0]            j_q, r_q;
	logic signed [DIST_W-1:0] left_q  [MAX_DEGREE+1];
	logic signed [DIST_W-1:0] right_q [MAX_DEGREE+1];
	logic [BW-1:0]            basis_q [MAX_DEGREE+1];
	logic signed [QW-1:0]     t_r_q, t_l_q, saved_q;
	logic signed [DEN_W-1:0]  den_q;
	logic                     zero_q;
	logic                     rd_oob_q;

	logic [DW-1:0]            d_cur;
	logic [IW-1:0]            n_cur;
	logic                     too_few;
	logic                     acc;
	logic                     ram_we;
	logic [IW-1:0]            rd_idx;
	logic [KNOT_W-1:0]        ram_rdata;
	logic signed [KNOT_W-1:0] knot;
	logic [IW-1:0]            mid;
	logic [IW-1:0]            nb1, idx1, idx_cl;
	logic signed [DEN_W-1:0]  den_now;
	logic                     div_start, div_done;
	logic signed [DIST_W-1:0] div_a;
	logic signed [DEN_W-1:0]  div_den;
	logic signed [QW-1:0]     div_quo;
	logic [IW-1:0]            bidx;
	logic [DW-1:0]            r_nx;
	logic [DW-1:0]            jr;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= DEGREE_RST;
			kcnt_q <= KNOTS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEGREE: deg_q  <= cfg_data[DEG_CFG_W-1:0];
				CFG_KNOTS:  kcnt_q <= cfg_data[CNT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective degree and knot count
	assign d_cur   = (32'(deg_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(deg_q);
	assign n_cur   = (32'(kcnt_q) > MAX_KNOTS) ? IW'(MAX_KNOTS) : IW'(kcnt_q);
	assign too_few = (32'(n_cur) < 32'(d_cur) + 2);

	assign busy = (state_q != S_IDLE);
	assign acc  = start && !busy;

	// knot table
	assign ram_we = acc && (item.mode == MODE_LOAD) && (32'(item.knot_slot) < MAX_KNOTS);

	always_comb begin
		unique case (state_q)
			S_RD1:   rd_idx = IW'(1);
			S_CHK1:  rd_idx = n_cur - IW'(1);
			S_BIS:   rd_idx = mid;
			S_LR:    rd_idx = idx_q + IW'(1) - IW'(j_q);
			S_LRL:   rd_idx = idx_q + IW'(j_q);
			default: rd_idx = '0;
		endcase
	end

	bbe_ram #(
		.WIDTH(KNOT_W),
		.DEPTH(MAX_KNOTS)
	) u_knots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(item.knot_slot)),
		.wdata(item.sample_value),
		.raddr(rd_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	// knots past the table read as zero
	assign knot = rd_oob_q ? '0 : $signed(ram_rdata);

	// bisection midpoint and span clamp
	assign mid    = IW'((low_q + high_q) >> 1);
	assign nb1    = n_cur - IW'(d_cur) - IW'(2);
	assign idx1   = (low_q > nb1) ? nb1 : low_q;
	assign idx_cl = (idx1 < IW'(d_cur)) ? IW'(d_cur) : idx1;

	// triangle denominator and shared divider
	assign r_nx    = r_q + DW'(1);
	assign jr      = j_q - r_q;
	assign den_now = DEN_W'(right_q[r_nx]) + DEN_W'(left_q[jr]);
	assign div_start = ((state_q == S_DEN) && (den_now != '0))
	                || ((state_q == S_DIVR) && div_done);
	assign div_a   = (state_q == S_DIVR) ? left_q[jr] : right_q[r_nx];
	assign div_den = (state_q == S_DEN) ? den_now : den_q;

	bbe_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (basis_q[r_q]),
		.a     (div_a),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_oob_q <= 1'b0;
			zero_q   <= 1'b0;
			j_q      <= '0;
			r_q      <= '0;
		end else begin
			rd_oob_q <= (32'(rd_idx) >= MAX_KNOTS);
			unique case (state_q)
				S_IDLE: begin
					if (acc && (item.mode == MODE_EVAL) && !too_few) begin
						x_q     <= item.sample_value;
						zero_q  <= 1'b0;
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_CHK1;
				S_CHK1: begin
					if (x_q < knot) begin
						low_q   <= '0;
						state_q <= S_CLAMP;
					end else begin
						state_q <= S_CHKL;
					end
				end
				S_CHKL: begin
					if (x_q == knot) begin
						low_q   <= n_cur - IW'(1);
						state_q <= S_CLAMP;
					end else begin
						low_q   <= '0;
						high_q  <= n_cur - IW'(1);
						state_q <= S_BIS;
					end
				end
				S_BIS: begin
					if (high_q - low_q > IW'(1)) begin
						mid_q   <= mid;
						state_q <= S_BISW;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_BISW: begin
					if (x_q < knot) begin
						high_q <= mid_q;
					end else begin
						low_q <= mid_q;
					end
					state_q <= S_BIS;
				end
				S_CLAMP: begin
					idx_q      <= idx_cl;
					basis_q[0] <= ONE_Q;
					j_q        <= DW'(1);
					r_q        <= '0;
					state_q    <= (d_cur == '0) ? S_OUT : S_LR;
				end
				S_LR: state_q <= S_LRL;
				S_LRL: begin
					left_q[j_q] <= DIST_W'(x_q) - DIST_W'(knot);
					state_q     <= S_LRR;
				end
				S_LRR: begin
					right_q[j_q] <= DIST_W'(knot) - DIST_W'(x_q);
					r_q          <= '0;
					saved_q      <= '0;
					state_q      <= S_DEN;
				end
				S_DEN: begin
					den_q <= den_now;
					if (den_now == '0) begin
						zero_q  <= 1'b1;
						t_r_q   <= '0;
						t_l_q   <= '0;
						state_q <= S_UPD;
					end else begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					if (div_done) begin
						t_r_q   <= div_quo;
						state_q <= S_DIVL;
					end
				end
				S_DIVL: begin
					if (div_done) begin
						t_l_q   <= div_quo;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					basis_q[r_q] <= sat_unit((QW+1)'(saved_q) + (QW+1)'(t_r_q));
					saved_q      <= t_l_q;
					if (r_q == j_q - DW'(1)) begin
						// row done: top entry takes the last left term
						basis_q[j_q] <= sat_unit((QW+1)'(t_l_q));
						r_q          <= '0;
						if (j_q == d_cur) begin
							state_q <= S_OUT;
						end else begin
							j_q     <= j_q + DW'(1);
							state_q <= S_LR;
						end
					end else begin
						r_q     <= r_nx;
						state_q <= S_DEN;
					end
				end
				S_OUT: begin
					if (r_q == d_cur) begin
						state_q <= S_IDLE;
					end else begin
						r_q <= r_nx;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat
	assign bidx                 = idx_q - IW'(d_cur) + IW'(r_q);
	assign strobe               = (state_q == S_OUT);
	assign result.basis_index   = IDX_OUT_W'(bidx);
	assign result.basis_value   = VAL_OUT_W'(basis_q[r_q]);
	assign result.last_of_point = (r_q == d_cur);
	assign result.zero_divisor  = zero_q;

	// results of one point come on back to back cycles
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_point |=> strobe)
		else $error("result burst broken");

	// the last beat of a point releases the block
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_of_point |=> !busy)
		else $error("busy after last beat");

	// a knot load starts no work
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (item.mode == MODE_LOAD) |=> !busy)
		else $error("load made block busy");

	// divider only started from the triangle states
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_DEN) || (state_q == S_DIVR))
		else $error("stray divider start");
endmodule

[rtl/bbe_ram.sv]
// generic single write port, single read port ram with registered read
module bbe_ram #(
	parameter int WIDTH = bbe_pkg::KNOT_W,
	parameter int DEPTH = bbe_pkg::DEF_MAX_KNOTS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/bbe_div.sv]
// shared scaled divider: round(num * a / den), bit-serial restoring division
module bbe_div #(
	parameter int FRAC_BITS = bbe_pkg::DEF_FRAC_BITS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [FRAC_BITS:0]                            num,
	input  logic signed [bbe_pkg::DIST_W-1:0]             a,
	input  logic signed [bbe_pkg::DEN_W-1:0]              den,
	output logic                                          done,
	output logic signed [FRAC_BITS+bbe_pkg::KNOT_W+2:0]   quo
);
	import bbe_pkg::*;

	localparam int BW   = FRAC_BITS + 1;
	localparam int PW   = BW + KNOT_W;
	localparam int NUMW = PW + 1;
	localparam int QW   = NUMW + 1;
	localparam int CW   = $clog2(NUMW + 1);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_MUL  = 2'd1;
	localparam logic [1:0] D_ADD  = 2'd2;
	localparam logic [1:0] D_RUN  = 2'd3;

	logic [1:0]        st_q;
	logic [BW-1:0]     n_q;
	logic [KNOT_W-1:0] ua_q;
	logic [KNOT_W-1:0] ud_q;
	logic              neg_q;
	logic [PW-1:0]     prod_q;
	logic [NUMW-1:0]   dq_q;
	logic [KNOT_W-1:0] rem_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;

	logic [DIST_W-1:0] a_mag;
	logic [DEN_W-1:0]  d_mag;
	logic [KNOT_W:0]   trial;
	logic              qbit;

	// magnitudes; both fit in 32 bits as they are knot differences
	assign a_mag = a[DIST_W-1] ? DIST_W'(-a) : DIST_W'(a);
	assign d_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

	// one restoring step
	assign trial = {rem_q, dq_q[NUMW-1]};
	assign qbit  = (trial >= {1'b0, ud_q});

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						n_q   <= num;
						ua_q  <= a_mag[KNOT_W-1:0];
						ud_q  <= d_mag[KNOT_W-1:0];
						neg_q <= a[DIST_W-1] ^ den[DEN_W-1];
						st_q  <= D_MUL;
					end
				end
				D_MUL: begin
					prod_q <= PW'(n_q) * PW'(ua_q);
					st_q   <= D_ADD;
				end
				D_ADD: begin
					// half divisor added for round to nearest, ties away
					dq_q  <= NUMW'(prod_q) + NUMW'(ud_q >> 1);
					rem_q <= '0;
					cnt_q <= '0;
					st_q  <= D_RUN;
				end
				D_RUN: begin
					rem_q <= qbit ? KNOT_W'(trial - {1'b0, ud_q}) : trial[KNOT_W-1:0];
					dq_q  <= {dq_q[NUMW-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NUMW - 1)) begin
						done_q <= 1'b1;
						st_q   <= D_IDLE;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(QW'(dq_q)) : $signed(QW'(dq_q));
endmodule

[tb/sv/bspline_basis_evaluator_core_tb.sv]
// testbench for the b-spline basis evaluator: knot loads, evaluates, configuration sweeps
`timescale 1ns / 1ps

module bspline_basis_evaluator_core_tb;
	import bbe_pkg::*;

	localparam int N_KNOTS   = 64;
	localparam int TOP_DEG   = 7;
	localparam int FRAC      = 16;
	localparam longint UNIT  = 64'sd1 << FRAC;
	localparam int WD_LIMIT  = 200000;
	localparam int DRAIN_CYC = 3200;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	bbe_in_t  item = '0;
	logic     strobe;
	bbe_out_t result;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of block state
	logic signed [31:0] knot_mirror [N_KNOTS];
	int unsigned        deg_reg;
	int unsigned        cnt_reg;
	bbe_out_t           basis_pending [$];
	int                 fault_count = 0;
	int                 idle_pct = 0;
	int                 quiet_cycles = 0;

	bspline_basis_evaluator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.strobe(strobe), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint knot_val(int unsigned i);
		if (i >= N_KNOTS) return 0;
		return longint'(knot_mirror[i]);
	endfunction

	// rounded n*a/den, ties away from zero
	function automatic longint round_ratio(longint n, longint a, longint den);
		bit neg;
		longint unsigned ua, ud, q;
		neg = (a < 0) ^ (den < 0);
		ua = (a < 0) ? -a : a;
		ud = (den < 0) ? -den : den;
		q = (longint'(n) * ua + ud / 2) / ud;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clip_unit(longint v);
		if (v < 0) return 0;
		if (v > UNIT) return UNIT;
		return v;
	endfunction

	function automatic int unsigned span_of(longint x, int unsigned n);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = n - 1;
		if (x < knot_val(1)) return 0;
		if (x == knot_val(n - 1)) return n - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (x < knot_val(mid)) hi = mid; else lo = mid;
		end
		return lo;
	endfunction

	// cox-de boor triangle for one point, queueing its basis values
	task automatic predict_basis(longint x);
		longint nv [TOP_DEG+1];
		longint lt [TOP_DEG+1];
		longint rt [TOP_DEG+1];
		longint saved, den, tr, tl;
		int unsigned d, n, sp;
		bit hit;
		bbe_out_t o;
		hit = 0;
		d = (deg_reg > TOP_DEG) ? TOP_DEG : deg_reg;
		n = (cnt_reg > N_KNOTS) ? N_KNOTS : cnt_reg;
		if (n < d + 2) return;
		sp = span_of(x, n);
		if (sp > n - d - 2) sp = n - d - 2;
		if (sp < d) sp = d;
		for (int i = 0; i <= TOP_DEG; i++) begin
			lt[i] = 0;
			rt[i] = 0;
			nv[i] = 0;
		end
		nv[0] = UNIT;
		for (int unsigned j = 1; j <= d; j++) begin
			lt[j] = x - knot_val(sp + 1 - j);
			rt[j] = knot_val(sp + j) - x;
			saved = 0;
			for (int unsigned r = 0; r < j; r++) begin
				den = rt[r+1] + lt[j-r];
				if (den == 0) begin
					hit = 1;
					tr = 0;
					tl = 0;
				end else begin
					tr = round_ratio(nv[r], rt[r+1], den);
					tl = round_ratio(nv[r], lt[j-r], den);
				end
				nv[r] = clip_unit(saved + tr);
				saved = tl;
			end
			nv[j] = clip_unit(saved);
		end
		for (int unsigned r = 0; r <= d; r++) begin
			o.basis_index = 6'(sp - d + r);
			o.basis_value = 17'(nv[r]);
			o.last_of_point = (r == d);
			o.zero_divisor = hit;
			basis_pending.push_back(o);
		end
	endtask

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(logic m, logic [5:0] slot, logic [31:0] v);
		while ($urandom_range(99, 0) < idle_pct) @(posedge clk);
		start <= 1'b1;
		item <= '{mode: m, knot_slot: slot, sample_value: v};
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b0;
		if (m == MODE_LOAD) begin
			knot_mirror[slot] = v;
		end else begin
			predict_basis(longint'($signed(v)));
		end
		@(posedge clk);
	endtask

	task automatic load_knot(int unsigned slot, logic [31:0] v);
		send_beat(MODE_LOAD, 6'(slot), v);
	endtask

	task automatic eval_point(logic [31:0] x);
		send_beat(MODE_EVAL, 6'($urandom_range(63, 0)), x);
	endtask

	// wait until idle, then for the block's own tail
	task automatic settle();
		while (basis_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 7'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_DEGREE) deg_reg = v & 7; else cnt_reg = v & 7'h7f;
		@(posedge clk);
	endtask

	task automatic set_shape(int unsigned d, int unsigned n);
		settle();
		write_reg(CFG_DEGREE, d);
		write_reg(CFG_KNOTS, n);
	endtask

	// a sorted knot vector with random steps, zero steps now and then
	task automatic load_sorted(int unsigned n, int unsigned step_max);
		logic signed [31:0] k;
		k = -$signed(32'(n * step_max / 2));
		for (int unsigned i = 0; i < n; i++) begin
			load_knot(i, k);
			k = k + (($urandom_range(5, 0) == 0) ? 0 : $urandom_range(step_max, 1));
		end
	endtask

	// point near the knot range, sometimes on a knot, sometimes outside
	function automatic logic [31:0] pick_point(int unsigned n);
		int unsigned s;
		s = $urandom_range(n - 1, 0);
		case ($urandom_range(5, 0))
			0: return knot_mirror[s];
			1: return knot_mirror[s] + $urandom_range(3, 0) - 1;
			2: return $urandom();
			default: return knot_mirror[s] + $urandom_range(32'h3ffff, 0);
		endcase
	endfunction

	// directed: field extremes, both modes, special cases
	task automatic test_directed();
		for (int i = 0; i < 16; i++) load_knot(i, 32'(i) << 16);
		eval_point(32'h0008_0000);
		eval_point(32'h8000_0000);
		eval_point(32'h7fff_ffff);
		eval_point(32'h000f_0000);
		eval_point(32'h0000_0000);
		eval_point(32'h0010_0000);
		load_knot(63, 32'hffff_ffff);
		load_knot(4, 32'h0003_0000);
		eval_point(32'h0003_0000);
		set_shape(0, 16);
		eval_point(32'h0005_8000);
		set_shape(7, 8);
		eval_point(32'h0004_0000);
		set_shape(3, 4);
		eval_point(32'h0002_0000);
		set_shape(1, 4);
		eval_point(32'h0001_8000);
		set_shape(3, 16);
	endtask

	// random sorted tables under several shapes and idle rates
	task automatic test_random(int beats, int pct);
		int unsigned d, n;
		idle_pct = pct;
		for (int done = 0; done < beats;) begin
			d = $urandom_range(7, 0);
			case ($urandom_range(3, 0))
				0: n = 64;
				1: n = $urandom_range(127, 65);
				default: n = $urandom_range(20, 4);
			endcase
			if (d > 3 && $urandom_range(2, 0) != 0) d = $urandom_range(3, 1);
			set_shape(d, n);
			load_sorted((n > N_KNOTS) ? N_KNOTS : n, $urandom_range(32'h40000, 1));
			done += (n > N_KNOTS) ? N_KNOTS : n;
			for (int i = 0; i < 6; i++) begin
				if ($urandom_range(9, 0) == 0)
					load_knot($urandom_range(((n > N_KNOTS) ? N_KNOTS : n) - 1, 0),
						$urandom());
				else
					eval_point(pick_point((n > N_KNOTS) ? N_KNOTS : n));
				done++;
			end
		end
		idle_pct = 0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (basis_pending.size() == 0) begin
				$error("unexpected result beat %p", result);
				fault_count++;
			end else begin : cmp
				bbe_out_t e;
				e = basis_pending.pop_front();
				if (result.basis_index !== e.basis_index) begin
					$error("basis_index exp %0d got %0d", e.basis_index, result.basis_index);
					fault_count++;
				end
				if (result.basis_value !== e.basis_value) begin
					$error("basis_value exp %0d got %0d", e.basis_value, result.basis_value);
					fault_count++;
				end
				if (result.last_of_point !== e.last_of_point) begin
					$error("last_of_point exp %0b got %0b", e.last_of_point,
						result.last_of_point);
					fault_count++;
				end
				if (result.zero_divisor !== e.zero_divisor) begin
					$error("zero_divisor exp %0b got %0b", e.zero_divisor,
						result.zero_divisor);
					fault_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat accepted, no result and no cfg write
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		deg_reg = DEGREE_RST;
		cnt_reg = KNOTS_RST;
		for (int i = 0; i < N_KNOTS; i++) begin
			knot_mirror[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(80, 0);
		test_random(80, 81);
		test_random(45, 14);
		test_random(45, 0);
		settle();
		if (fault_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
